// ===== rtl/jhmp_pkg.sv =====
// Package for the JPEG header marker parser: result codes, marker codes and helpers.
package jhmp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SCAN      = 3'd0,
    ST_NOT_JPEG  = 3'd1,
    ST_PADDING   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_EOI       = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  // Marker and framing bytes
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] MRK_SOI   = 8'hD8;
  localparam logic [7:0] MRK_EOI   = 8'hD9;
  localparam logic [7:0] MRK_SOS   = 8'hDA;
  localparam logic [7:0] MRK_SOF_LO = 8'hC0;
  localparam logic [7:0] MRK_SOF_HI = 8'hCF;
  localparam logic [7:0] MRK_DHT   = 8'hC4;
  localparam logic [7:0] MRK_JPG   = 8'hC8;
  localparam logic [7:0] MRK_DAC   = 8'hCC;

  // Padding limit and frame header layout
  localparam logic [2:0]  MAX_PAD       = 3'd6;
  localparam logic [15:0] MIN_LEN       = 16'd2;
  localparam logic [15:0] MIN_SOF_LEN   = 16'd8;
  localparam logic [15:0] OFS_HEIGHT_HI = 16'd3;
  localparam logic [15:0] OFS_HEIGHT_LO = 16'd4;
  localparam logic [15:0] OFS_WIDTH_HI  = 16'd5;
  localparam logic [15:0] OFS_WIDTH_LO  = 16'd6;
  localparam logic [15:0] OFS_COMPS     = 16'd7;
  localparam logic [7:0]  COLOUR_COMPS  = 8'd3;

  // True for a start-of-frame marker (C0..CF without DHT, JPG and DAC)
  function automatic logic is_frame_marker(input logic [7:0] m);
    is_frame_marker = (m >= MRK_SOF_LO) && (m <= MRK_SOF_HI) &&
                      (m != MRK_DHT) && (m != MRK_JPG) && (m != MRK_DAC);
  endfunction

endpackage

// ===== rtl/jpeg_header_marker_parser.sv =====
// JPEG header marker parser: byte-wide marker walk with a two-entry result buffer.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one byte of a JPEG file per
//   item, with in_end_of_file set on the last byte of each file. The block
//   checks the FF D8 start pair, walks the marker segments and captures the
//   last frame header (height, width, colour, marker code). It emits exactly
//   one result item per file on the output channel (out_valid / out_stall):
//   at the scan header, at EOI, on a bad start, too much padding, a length
//   below two, or at end of file if nothing was reported earlier. Bytes after
//   a result are swallowed until the end-of-file byte.
//   Throughput is one byte per cycle while in_stall is low; the whole state
//   update is combinational logic, and a result is registered into the output
//   register, or into the skid entry while the output register is held.
//   An output register plus one skid entry part the two sides, so bytes keep
//   flowing while a result waits; in_stall rises only when both entries hold
//   a result, which is registered and does not depend on out_stall directly.
//   Synchronous active-low reset empties both entries and returns the parser
//   to expect the first start byte of a new file.
module jpeg_header_marker_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_image_height,
  output logic [15:0] out_image_width,
  output logic        out_is_color,
  output logic [7:0]  out_coding_process,
  output logic        out_frame_found
);

  typedef enum logic [2:0] {
    PH_START1, PH_START2, PH_MARKER, PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
    logic        color;
    logic [7:0]  process;
    logic        found;
  } result_t;

  // Parser state
  phase_t      phase_r,    phase_nxt;
  logic [2:0]  pad_r,      pad_nxt;
  logic [7:0]  marker_r,   marker_nxt;
  logic [15:0] seg_len_r,  seg_len_nxt;
  logic [15:0] seg_ofs_r,  seg_ofs_nxt;
  logic [15:0] height_r,   height_nxt;
  logic [15:0] width_r,    width_nxt;
  logic        color_r,    color_nxt;
  logic [7:0]  process_r,  process_nxt;
  logic        found_r,    found_nxt;
  logic [15:0] p_height_r, p_height_nxt;
  logic [15:0] p_width_r,  p_width_nxt;
  logic        p_color_r,  p_color_nxt;

  // Result buffer
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic        in_acc, out_pop, res_valid, sof;
  logic [2:0]  res_status;
  logic [15:0] ofs_inc, full_len;
  result_t     res;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_pop  = out_valid_r && !out_stall;
  assign sof      = jhmp_pkg::is_frame_marker(marker_r);
  assign ofs_inc  = seg_ofs_r + 16'd1;
  assign full_len = {seg_len_r[15:8], in_stream_byte};

  // Next state for one accepted byte
  always_comb begin
    phase_nxt    = phase_r;
    pad_nxt      = pad_r;
    marker_nxt   = marker_r;
    seg_len_nxt  = seg_len_r;
    seg_ofs_nxt  = seg_ofs_r;
    height_nxt   = height_r;
    width_nxt    = width_r;
    color_nxt    = color_r;
    process_nxt  = process_r;
    found_nxt    = found_r;
    p_height_nxt = p_height_r;
    p_width_nxt  = p_width_r;
    p_color_nxt  = p_color_r;
    res_valid    = 1'b0;
    res_status   = jhmp_pkg::ST_SCAN;

    case (phase_r)
      PH_START1: begin
        if (in_stream_byte != jhmp_pkg::BYTE_FF) begin
          res_valid  = 1'b1;
          res_status = jhmp_pkg::ST_NOT_JPEG;
        end else begin
          phase_nxt = PH_START2;
        end
      end
      PH_START2: begin
        if (in_stream_byte != jhmp_pkg::MRK_SOI) begin
          res_valid  = 1'b1;
          res_status = jhmp_pkg::ST_NOT_JPEG;
        end else begin
          phase_nxt = PH_MARKER;
          pad_nxt   = 3'd0;
        end
      end
      PH_MARKER: begin
        if (in_stream_byte == jhmp_pkg::BYTE_FF) begin
          if (pad_r >= jhmp_pkg::MAX_PAD) begin
            res_valid  = 1'b1;
            res_status = jhmp_pkg::ST_PADDING;
          end else begin
            pad_nxt = pad_r + 3'd1;
          end
        end else begin
          pad_nxt    = 3'd0;
          marker_nxt = in_stream_byte;
          if (in_stream_byte == jhmp_pkg::MRK_EOI) begin
            res_valid  = 1'b1;
            res_status = jhmp_pkg::ST_EOI;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        seg_len_nxt = {in_stream_byte, 8'd0};
        phase_nxt   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len_nxt = full_len;
        if (full_len < jhmp_pkg::MIN_LEN) begin
          res_valid  = 1'b1;
          res_status = jhmp_pkg::ST_BAD_LEN;
        end else if (marker_r == jhmp_pkg::MRK_SOS) begin
          res_valid  = 1'b1;
          res_status = jhmp_pkg::ST_SCAN;
        end else begin
          seg_ofs_nxt  = jhmp_pkg::MIN_LEN;
          p_height_nxt = 16'd0;
          p_width_nxt  = 16'd0;
          p_color_nxt  = 1'b0;
          phase_nxt    = (full_len == jhmp_pkg::MIN_LEN) ? PH_MARKER : PH_BODY;
        end
      end
      PH_BODY: begin
        // Frame header fields by offset within the segment
        if (sof) begin
          if (seg_ofs_r == jhmp_pkg::OFS_HEIGHT_HI) p_height_nxt = {in_stream_byte, 8'd0};
          if (seg_ofs_r == jhmp_pkg::OFS_HEIGHT_LO)
            p_height_nxt = {p_height_r[15:8], in_stream_byte};
          if (seg_ofs_r == jhmp_pkg::OFS_WIDTH_HI) p_width_nxt = {in_stream_byte, 8'd0};
          if (seg_ofs_r == jhmp_pkg::OFS_WIDTH_LO)
            p_width_nxt = {p_width_r[15:8], in_stream_byte};
          if (seg_ofs_r == jhmp_pkg::OFS_COMPS)
            p_color_nxt = (in_stream_byte == jhmp_pkg::COLOUR_COMPS);
        end
        seg_ofs_nxt = ofs_inc;
        // Last byte of the segment: commit a long enough frame header
        if (ofs_inc >= seg_len_r) begin
          if (sof && (seg_len_r >= jhmp_pkg::MIN_SOF_LEN)) begin
            height_nxt  = p_height_nxt;
            width_nxt   = p_width_nxt;
            color_nxt   = p_color_nxt;
            process_nxt = marker_r;
            found_nxt   = 1'b1;
          end
          phase_nxt = PH_MARKER;
          pad_nxt   = 3'd0;
        end
      end
      default: ;
    endcase

    // End of file with nothing reported yet
    if (!res_valid && in_end_of_file && (phase_nxt != PH_DONE)) begin
      res_valid  = 1'b1;
      res_status = jhmp_pkg::ST_TRUNCATED;
    end
    if (res_valid) phase_nxt = PH_DONE;
  end

  assign res = '{status: res_status, height: height_nxt, width: width_nxt,
                 color: color_nxt, process: process_nxt, found: found_nxt};

  // State registers and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START1;
      pad_r        <= 3'd0;
      marker_r     <= 8'd0;
      seg_len_r    <= 16'd0;
      seg_ofs_r    <= 16'd0;
      height_r     <= 16'd0;
      width_r      <= 16'd0;
      color_r      <= 1'b0;
      process_r    <= 8'd0;
      found_r      <= 1'b0;
      p_height_r   <= 16'd0;
      p_width_r    <= 16'd0;
      p_color_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_end_of_file) begin
          // a new file starts with the next item
          phase_r    <= PH_START1;
          pad_r      <= 3'd0;
          marker_r   <= 8'd0;
          seg_len_r  <= 16'd0;
          seg_ofs_r  <= 16'd0;
          height_r   <= 16'd0;
          width_r    <= 16'd0;
          color_r    <= 1'b0;
          process_r  <= 8'd0;
          found_r    <= 1'b0;
          p_height_r <= 16'd0;
          p_width_r  <= 16'd0;
          p_color_r  <= 1'b0;
        end else begin
          phase_r    <= phase_nxt;
          pad_r      <= pad_nxt;
          marker_r   <= marker_nxt;
          seg_len_r  <= seg_len_nxt;
          seg_ofs_r  <= seg_ofs_nxt;
          height_r   <= height_nxt;
          width_r    <= width_nxt;
          color_r    <= color_nxt;
          process_r  <= process_nxt;
          found_r    <= found_nxt;
          p_height_r <= p_height_nxt;
          p_width_r  <= p_width_nxt;
          p_color_r  <= p_color_nxt;
        end
      end

      // Output register with one skid entry behind it
      if (skid_valid_r) begin
        if (out_pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc && res_valid) begin
        if (!out_valid_r || out_pop) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_image_height   = out_r.height;
  assign out_image_width    = out_r.width;
  assign out_is_color       = out_r.color;
  assign out_coding_process = out_r.process;
  assign out_frame_found    = out_r.found;

  // Skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  // Padding count never passes its limit
  a_pad_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r <= jhmp_pkg::MAX_PAD)
    else $error("padding count beyond limit");

  // A result mid-file parks the parser until end of file
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && !in_end_of_file) |=> (phase_r == PH_DONE))
    else $error("parser not parked after a result");

  // End of file always returns the parser to the start of a new file
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_file) |=> (phase_r == PH_START1 && !found_r))
    else $error("parser not restarted after end of file");

  // Every end-of-file byte that is not preceded by a result yields one
  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_file && phase_r != PH_DONE) |-> res_valid)
    else $error("file ended without a result");

endmodule

// ===== tb/jhmp_header_checker.sv =====
// Checker for the JPEG header marker parser: predicts each file's result and compares it.
`timescale 1ns / 1ps
module jhmp_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_file,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_image_height,
  input  logic [15:0] out_image_width,
  input  logic        out_is_color,
  input  logic [7:0]  out_coding_process,
  input  logic        out_frame_found,
  output int          fail_count,
  output int          pending_count
);

  typedef enum logic [2:0] {
    WAIT_FF,
    WAIT_SOI,
    WAIT_MARKER,
    LEN_HI,
    LEN_LO,
    SKIP_BODY,
    SWALLOW
  } walk_phase_t;

  typedef struct packed {
    jhmp_pkg::status_t status;
    logic [15:0]       height;
    logic [15:0]       width;
    logic              colour;
    logic [7:0]        process;
    logic              found;
  } header_result_t;

  // Walk state of the file being received
  walk_phase_t    phase;
  logic [2:0]     ff_run;
  logic [7:0]     cur_marker;
  logic [15:0]    seg_len;
  logic [15:0]    seg_pos;
  // Frame fields taken so far, and those of the frame segment being read
  logic [15:0]    frm_height;
  logic [15:0]    frm_width;
  logic           frm_colour;
  logic [7:0]     frm_process;
  logic           frm_seen;
  logic [15:0]    new_height;
  logic [15:0]    new_width;
  logic [7:0]     new_comps;

  header_result_t expected_results[$];
  header_result_t want;

  // SOF0..SOF15, leaving out DHT, JPG and DAC which share the range
  function automatic logic frame_header(input logic [7:0] m);
    return (m >= jhmp_pkg::MRK_SOF_LO) && (m <= jhmp_pkg::MRK_SOF_HI) &&
           (m != jhmp_pkg::MRK_DHT) && (m != jhmp_pkg::MRK_JPG) &&
           (m != jhmp_pkg::MRK_DAC);
  endfunction

  task automatic clear_walk();
    phase       = WAIT_FF;
    ff_run      = '0;
    cur_marker  = '0;
    seg_len     = '0;
    seg_pos     = '0;
    frm_height  = '0;
    frm_width   = '0;
    frm_colour  = 1'b0;
    frm_process = '0;
    frm_seen    = 1'b0;
    new_height  = '0;
    new_width   = '0;
    new_comps   = '0;
  endtask

  // One byte of the file; queues a result when the file's outcome is settled
  task automatic walk_byte(input logic [7:0] b, input logic eof);
    logic              done;
    logic              sof;
    jhmp_pkg::status_t st;
    header_result_t    r;
    done = 1'b0;
    st   = jhmp_pkg::ST_SCAN;
    case (phase)
      WAIT_FF: begin
        if (b != jhmp_pkg::BYTE_FF) begin
          done = 1'b1;
          st   = jhmp_pkg::ST_NOT_JPEG;
        end else begin
          phase = WAIT_SOI;
        end
      end
      WAIT_SOI: begin
        if (b != jhmp_pkg::MRK_SOI) begin
          done = 1'b1;
          st   = jhmp_pkg::ST_NOT_JPEG;
        end else begin
          phase  = WAIT_MARKER;
          ff_run = '0;
        end
      end
      WAIT_MARKER: begin
        if (b == jhmp_pkg::BYTE_FF) begin
          if (ff_run >= jhmp_pkg::MAX_PAD) begin
            done = 1'b1;
            st   = jhmp_pkg::ST_PADDING;
          end else begin
            ff_run = ff_run + 3'd1;
          end
        end else begin
          ff_run     = '0;
          cur_marker = b;
          if (b == jhmp_pkg::MRK_EOI) begin
            done = 1'b1;
            st   = jhmp_pkg::ST_EOI;
          end else begin
            phase = LEN_HI;
          end
        end
      end
      LEN_HI: begin
        seg_len = {b, 8'h00};
        phase   = LEN_LO;
      end
      LEN_LO: begin
        seg_len[7:0] = b;
        if (seg_len < jhmp_pkg::MIN_LEN) begin
          done = 1'b1;
          st   = jhmp_pkg::ST_BAD_LEN;
        end else if (cur_marker == jhmp_pkg::MRK_SOS) begin
          done = 1'b1;
          st   = jhmp_pkg::ST_SCAN;
        end else begin
          // the length counts its own two bytes
          seg_pos    = jhmp_pkg::MIN_LEN;
          new_height = '0;
          new_width  = '0;
          new_comps  = '0;
          phase      = (seg_len == jhmp_pkg::MIN_LEN) ? WAIT_MARKER : SKIP_BODY;
        end
      end
      SKIP_BODY: begin
        sof = frame_header(cur_marker);
        if (sof) begin
          case (seg_pos)
            jhmp_pkg::OFS_HEIGHT_HI: new_height[15:8] = b;
            jhmp_pkg::OFS_HEIGHT_LO: new_height[7:0]  = b;
            jhmp_pkg::OFS_WIDTH_HI:  new_width[15:8]  = b;
            jhmp_pkg::OFS_WIDTH_LO:  new_width[7:0]   = b;
            jhmp_pkg::OFS_COMPS:     new_comps        = b;
            default: ;
          endcase
        end
        seg_pos = seg_pos + 16'd1;
        if (seg_pos >= seg_len) begin
          // short frame headers are skipped without touching the fields
          if (sof && (seg_len >= jhmp_pkg::MIN_SOF_LEN)) begin
            frm_height  = new_height;
            frm_width   = new_width;
            frm_colour  = (new_comps == jhmp_pkg::COLOUR_COMPS);
            frm_process = cur_marker;
            frm_seen    = 1'b1;
          end
          phase  = WAIT_MARKER;
          ff_run = '0;
        end
      end
      default: ;
    endcase

    if (!done && eof && (phase != SWALLOW)) begin
      done = 1'b1;
      st   = jhmp_pkg::ST_TRUNCATED;
    end

    if (done) begin
      r.status  = st;
      r.height  = frm_height;
      r.width   = frm_width;
      r.colour  = frm_colour;
      r.process = frm_process;
      r.found   = frm_seen;
      expected_results.push_back(r);
      phase = SWALLOW;
    end

    // end of file starts a fresh one
    if (eof) clear_walk();
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_walk();
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) walk_byte(in_stream_byte, in_end_of_file);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with none expected: status %0d", out_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("image_height", want.height, out_image_height);
          check_field("image_width", want.width, out_image_width);
          check_field("is_color", want.colour, out_is_color);
          check_field("coding_process", want.process, out_coding_process);
          check_field("frame_found", want.found, out_frame_found);
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== tb/jpeg_header_marker_parser_tb.sv =====
// Testbench top for the JPEG header marker parser: byte stream stimulus, flow control, verdict.
`timescale 1ns / 1ps
module jpeg_header_marker_parser_tb;

  // Markers the stimulus uses beyond those the block decodes
  localparam logic [7:0] MRK_APP0 = 8'hE0;
  localparam logic [7:0] MRK_DQT  = 8'hDB;
  localparam logic [7:0] MRK_COM  = 8'hFE;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [15:0] out_image_height;
  logic [15:0] out_image_width;
  logic        out_is_color;
  logic [7:0]  out_coding_process;
  logic        out_frame_found;

  logic        rx_stall    = 1'b0;
  logic        hold_off    = 1'b0;
  logic        squeeze_req = 1'b0;
  logic        tx_busy     = 1'b1;
  logic        rx_busy     = 1'b1;
  int          fail_count;
  int          pending_count;
  int          bytes_sent  = 0;
  logic [7:0]  file_bytes[$];

  assign out_stall = rx_stall | hold_off;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jpeg_header_marker_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_image_height   (out_image_height),
    .out_image_width    (out_image_width),
    .out_is_color       (out_is_color),
    .out_coding_process (out_coding_process),
    .out_frame_found    (out_frame_found)
  );

  jhmp_header_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_image_height   (out_image_height),
    .out_image_width    (out_image_width),
    .out_is_color       (out_is_color),
    .out_coding_process (out_coding_process),
    .out_frame_found    (out_frame_found),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  // Offer one byte from a falling edge and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = tx_busy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    int i;
    tx_busy = ($urandom_range(0, 3) != 0);
    rx_busy = ($urandom_range(0, 3) != 0);
    for (i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // Fill bytes ahead of a marker; usually one, sometimes none or up to the limit
  task automatic push_padding();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 1;
    repeat (n) file_bytes.push_back(jhmp_pkg::BYTE_FF);
  endtask

  task automatic push_frame_header();
    logic [7:0]  m;
    logic [15:0] len;
    int          p;
    m   = jhmp_pkg::MRK_SOF_LO | 8'($urandom_range(0, 15));
    len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(2, 7))
                                      : 16'($urandom_range(8, 14));
    file_bytes.push_back(m);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
    // height and width are plain random body bytes
    for (p = 2; p < len; p++) begin
      if (p == jhmp_pkg::OFS_COMPS)
        file_bytes.push_back($urandom_range(0, 1) ? jhmp_pkg::COLOUR_COMPS
                                                  : 8'($urandom_range(0, 255)));
      else
        file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_other_segment();
    logic [7:0]  m;
    logic [15:0] len;
    case ($urandom_range(0, 3))
      0: m = MRK_APP0 | 8'($urandom_range(0, 15));
      1: m = MRK_DQT;
      2: m = MRK_COM;
      default: begin
        m = 8'($urandom_range(0, 254));
        while (m == jhmp_pkg::MRK_EOI || m == jhmp_pkg::MRK_SOS) m = 8'($urandom_range(0, 254));
      end
    endcase
    len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(100, 300))
                                       : 16'($urandom_range(2, 10));
    file_bytes.push_back(m);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
    repeat (len - 2) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // How the file closes, followed by up to three random trailing bytes
  task automatic push_ending();
    logic [15:0] len;
    case ($urandom_range(0, 6))
      0, 1: begin
        len = 16'($urandom_range(2, 65535));
        file_bytes.push_back(jhmp_pkg::MRK_SOS);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
      end
      2: file_bytes.push_back(jhmp_pkg::MRK_EOI);
      3: begin
        file_bytes.push_back($urandom_range(0, 1) ? jhmp_pkg::MRK_SOS : MRK_COM);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'($urandom_range(0, 1)));
      end
      4: begin
        // segment cut off by the end of file
        len = 16'($urandom_range(256, 65535));
        file_bytes.push_back(MRK_APP0 | 8'($urandom_range(0, 15)));
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
      end
      5: repeat (7) file_bytes.push_back(jhmp_pkg::BYTE_FF);
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_file();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      file_bytes.push_back(jhmp_pkg::BYTE_FF);
      file_bytes.push_back(jhmp_pkg::MRK_SOI);
      repeat ($urandom_range(0, 4)) begin
        push_padding();
        if ($urandom_range(0, 1)) push_frame_header();
        else push_other_segment();
      end
      push_padding();
      push_ending();
      // a damaged file now and then
      if (sel == 1)
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  // Result side: random hold-off before each item
  initial begin
    int hold;
    forever begin
      hold = rx_busy ? $urandom_range(0, 14) : 0;
      if (hold > 0) begin
        rx_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Long receiver hold-off so the result buffer fills and the input backs up
  initial begin
    wait (squeeze_req);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (400) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int  drain;
    logic squeezed;
    squeezed = 1'b0;
    drain    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bad first byte
    file_bytes = '{8'h00};
    send_file();
    // seventh fill byte in a row
    file_bytes = '{jhmp_pkg::BYTE_FF, jhmp_pkg::MRK_SOI,
                   jhmp_pkg::BYTE_FF, jhmp_pkg::BYTE_FF, jhmp_pkg::BYTE_FF,
                   jhmp_pkg::BYTE_FF, jhmp_pkg::BYTE_FF, jhmp_pkg::BYTE_FF,
                   jhmp_pkg::BYTE_FF};
    send_file();
    // largest frame, colour, marker without a fill byte, then end of image
    file_bytes = '{jhmp_pkg::BYTE_FF, jhmp_pkg::MRK_SOI, jhmp_pkg::MRK_SOF_HI,
                   8'h00, 8'h08, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   jhmp_pkg::COLOUR_COMPS, jhmp_pkg::MRK_EOI};
    send_file();
    // shortest scan header, then a byte that is ignored
    file_bytes = '{jhmp_pkg::BYTE_FF, jhmp_pkg::MRK_SOI, jhmp_pkg::MRK_SOS,
                   8'h00, 8'h02, jhmp_pkg::BYTE_FF};
    send_file();

    while (bytes_sent < 700) begin
      if (!squeezed && bytes_sent >= 300) begin
        squeezed    = 1'b1;
        squeeze_req = 1'b1;
        tx_busy     = 1'b0;
        repeat (20) send_byte(8'($urandom_range(0, 254)), 1'b1);
      end
      build_file();
      send_file();
    end
    in_valid <= 1'b0;

    while (pending_count != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
